@@ src/uvs_pkg.sv @@
// uvs_pkg: shared types and codes for the unique value stack.
// Holds the request/response payload structs, request and status codes,
// and the control struct for the shared compare unit. No dependencies.
package uvs_pkg;

   localparam int VALUE_W = 32;
   localparam int CAP_W   = 5;
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request kinds
   localparam logic [KIND_W-1:0] OP_PUSH    = 3'd0;
   localparam logic [KIND_W-1:0] OP_POP     = 3'd1;
   localparam logic [KIND_W-1:0] OP_PEEK    = 3'd2;
   localparam logic [KIND_W-1:0] OP_REVERSE = 3'd3;
   localparam logic [KIND_W-1:0] OP_CLEAR   = 3'd4;

   // response status codes
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_DUP   = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]         req_type;
      logic signed [VALUE_W-1:0] push_value;
   } uvs_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [VALUE_W-1:0] out_value;
      logic [CAP_W-1:0]          entry_count;
   } uvs_rsp_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } uvs_scan_ctl_type;

endpackage

@@ src/uvs_mem.sv @@
// uvs_mem: entry storage for the unique value stack.
// One write port and two registered read ports sharing one read enable.
// Depends on uvs_pkg for the value width.
module uvs_mem #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [uvs_pkg::VALUE_W-1:0]  wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr_b,
   output logic signed [uvs_pkg::VALUE_W-1:0]  rd_data_a,
   output logic signed [uvs_pkg::VALUE_W-1:0]  rd_data_b
);
   import uvs_pkg::*;

   logic signed [VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [VALUE_W-1:0] rd_a_ff;
   logic signed [VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/uvs_scan.sv @@
// uvs_scan: shared equality compare unit with a sticky match flag.
// Used by the sequencer to walk stored entries for duplicates.
// Depends on uvs_pkg for the value width and control struct.
module uvs_scan (
   input  logic                                clock,
   input  uvs_pkg::uvs_scan_ctl_type           ctl,
   input  logic signed [uvs_pkg::VALUE_W-1:0]  cand,
   input  logic signed [uvs_pkg::VALUE_W-1:0]  entry,
   output logic                                hit
);
   import uvs_pkg::*;

   logic hit_ff;
   logic hit_in;

   // hit includes the compare of this cycle
   assign hit    = hit_ff | (ctl.enable & (cand == entry));
   assign hit_in = ctl.clear ? 1'b0 : hit;

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
   end

endmodule

@@ src/unique_value_stack.sv @@
// unique_value_stack: bounded LIFO of distinct signed 32-bit values.
// Clear, refused push, empty pop/peek and reverse of fewer than two answer straight from idle;
// pop/peek go through one memory read; push does one compare per stored entry;
// reverse does two memory writes per swapped pair.
// Busy drops in the response cycle; a new request is taken only while not busy.
// The receiver cannot stall. Sync active-high reset: empty, capacity 16.
module unique_value_stack #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  uvs_pkg::uvs_req_type   req_data,
   output logic                   rsp_valid,
   output uvs_pkg::uvs_rsp_type   rsp_data,
   input  logic                   csr_wr_en,
   input  logic [uvs_pkg::CAP_W-1:0] csr_wr_data
);
   import uvs_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_REV_LO,
      ST_REV_HI
   } state_type;

   state_type                 state_ff, state_in;
   logic [CAP_W-1:0]          cap_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             hi_ff, hi_in;
   logic                      pend_ff, pend_in;
   logic [KIND_W-1:0]         op_ff, op_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   uvs_rsp_type               rsp_ff, rsp_in;

   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic signed [VALUE_W-1:0] mem_wdata;
   logic                      mem_re;
   logic [AW-1:0]             mem_raddr_a;
   logic [AW-1:0]             mem_raddr_b;
   logic signed [VALUE_W-1:0] mem_rdata_a;
   logic signed [VALUE_W-1:0] mem_rdata_b;

   uvs_scan_ctl_type          scan_ctl;
   logic                      scan_hit;

   logic                      full;
   logic                      accept;
   logic [CW-1:0]             cnt_m1;
   logic [AW-1:0]             lo;
   logic                      issue;

   // Effective capacity is min(capacity, DEPTH); a lowered capacity keeps
   // existing entries but refuses further pushes.
   assign full   = (CMPW'(count_ff) >= CMPW'(cap_ff)) || (count_ff >= CW'(DEPTH));
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;
   assign cnt_m1 = count_ff - CW'(1);
   assign lo     = idx_ff[AW-1:0];
   assign issue  = (idx_ff < count_ff);

   uvs_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_en     (mem_re),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (mem_rdata_a),
      .rd_data_b (mem_rdata_b)
   );

   // The one comparator: candidate value against each entry read back.
   uvs_scan u_scan (
      .clock (clock),
      .ctl   (scan_ctl),
      .cand  (value_ff),
      .entry (mem_rdata_a),
      .hit   (scan_hit)
   );

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      hi_in           = hi_ff;
      pend_in         = pend_ff;
      op_in           = op_ff;
      value_in        = value_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      mem_we          = 1'b0;
      mem_waddr       = lo;
      mem_wdata       = value_ff;
      mem_re          = 1'b0;
      mem_raddr_a     = lo;
      mem_raddr_b     = hi_ff;
      scan_ctl.clear  = 1'b0;
      scan_ctl.enable = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // capture the request
               op_in    = req_data.req_type;
               value_in = req_data.push_value;
               case (req_data.req_type)
                  OP_PUSH: begin
                     if (full) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.status    = STATUS_FULL;
                        rsp_in.out_value = '0;
                     end else begin
                        // start the duplicate walk from the bottom entry
                        idx_in         = '0;
                        pend_in        = 1'b0;
                        scan_ctl.clear = 1'b1;
                        state_in       = ST_SCAN;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.status    = STATUS_EMPTY;
                        rsp_in.out_value = '0;
                     end else begin
                        mem_re      = 1'b1;
                        mem_raddr_a = cnt_m1[AW-1:0];
                        state_in    = ST_READ;
                     end
                  end
                  OP_REVERSE: begin
                     if (count_ff < CW'(2)) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.status    = STATUS_OK;
                        rsp_in.out_value = '0;
                     end else begin
                        // fetch the outermost pair
                        mem_re      = 1'b1;
                        mem_raddr_a = '0;
                        mem_raddr_b = cnt_m1[AW-1:0];
                        idx_in      = '0;
                        hi_in       = cnt_m1[AW-1:0];
                        state_in    = ST_REV_LO;
                     end
                  end
                  OP_CLEAR: begin
                     count_in         = '0;
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = STATUS_OK;
                     rsp_in.out_value = '0;
                  end
                  default: begin
                     // unused codes: report ok, change nothing
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = STATUS_OK;
                     rsp_in.out_value = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one read issued and one compare done per cycle
            scan_ctl.enable = pend_ff;
            pend_in         = issue;
            if (issue) begin
               mem_re      = 1'b1;
               mem_raddr_a = lo;
               idx_in      = idx_ff + CW'(1);
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_value = '0;
               if (scan_hit) begin
                  rsp_in.status = STATUS_DUP;
               end else begin
                  mem_we        = 1'b1;
                  mem_waddr     = count_ff[AW-1:0];
                  mem_wdata     = value_ff;
                  count_in      = count_ff + CW'(1);
                  rsp_in.status = STATUS_OK;
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.status    = STATUS_OK;
            rsp_in.out_value = mem_rdata_a;
            if (op_ff == OP_POP) begin
               count_in = cnt_m1;
            end
            state_in = ST_IDLE;
         end
         ST_REV_LO: begin
            // low slot takes the high entry
            mem_we    = 1'b1;
            mem_waddr = lo;
            mem_wdata = mem_rdata_b;
            state_in  = ST_REV_HI;
         end
         ST_REV_HI: begin
            // high slot takes the low entry, then advance inward
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            mem_wdata = mem_rdata_a;
            idx_in    = idx_ff + CW'(1);
            hi_in     = hi_ff - AW'(1);
            if (({1'b0, lo} + (AW+1)'(2)) < {1'b0, hi_ff}) begin
               mem_re      = 1'b1;
               mem_raddr_a = lo + AW'(1);
               mem_raddr_b = hi_ff - AW'(1);
               state_in    = ST_REV_LO;
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = STATUS_OK;
               rsp_in.out_value = '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // every response reports the count after the request
      if (rsp_valid_in) begin
         rsp_in.entry_count = CAP_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
      idx_ff   <= idx_in;
      hi_ff    <= hi_in;
      op_ff    <= op_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stack never holds more than DEPTH entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   // a response is only issued when the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobed while sequencer busy");

   // a push accepted at capacity is refused at once
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.req_type == OP_PUSH) && full)
      |=> (rsp_valid_ff && (rsp_ff.status == STATUS_FULL)))
      else $error("push at capacity not refused");

   // a completed push grows the stack by exactly one
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !issue && !scan_hit)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted push did not add one entry");

endmodule
